// ----- hdl/string_key_bucket_hash_unit_macros.svh -----
// ---------------------------------------------------------------------------
// String key bucket hash assertion macros
// Shared concurrent assertion forms, clocked on clk; all but SKBH_ASSERT_ALWAYS are off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef STRING_KEY_BUCKET_HASH_UNIT_MACROS_SVH
`define STRING_KEY_BUCKET_HASH_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define SKBH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skbh assertion failed");

// next-cycle implication, off during reset
`define SKBH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skbh assertion failed");

// same-cycle implication, checked during reset too
`define SKBH_ASSERT_ALWAYS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("skbh assertion failed");

`endif

// ----- hdl/skbh_pkg.sv -----
// ---------------------------------------------------------------------------
// String key bucket hash package
// Widths, constants and the CRC and mix step functions of the hash unit.
// ---------------------------------------------------------------------------
package skbh_pkg;

	localparam int BYTE_W  = 8;
	localparam int CRC_W   = 32;
	localparam int HASH_W  = 64;
	localparam int INDEX_W = 31;
	localparam int LOG2_W  = 5;

	localparam logic [CRC_W-1:0]   CRC_POLY       = 32'hEDB8_8320;
	localparam logic [INDEX_W-1:0] MIX_MULT_LO    = 31'(32'd2654435761);
	localparam logic [LOG2_W-1:0]  TABLE_LOG2_RST = 5'd8;

	typedef logic [CRC_W-1:0]   crc_t;
	typedef logic [HASH_W-1:0]  hash_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [LOG2_W-1:0]  log2_t;

	function automatic crc_t crc_byte(input crc_t crc_in, input logic [BYTE_W-1:0] data);
		crc_t c;
		c = crc_in ^ {24'd0, data};
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// first four mix steps
	function automatic hash_t mix_lo(input hash_t h_in);
		hash_t h;
		h = h_in;
		h = h + (h << 12);
		h = h ^ (h >> 22);
		h = h + (h << 4);
		h = h ^ (h >> 9);
		return h;
	endfunction

	// last four mix steps
	function automatic hash_t mix_hi(input hash_t h_in);
		hash_t h;
		h = h_in;
		h = h + (h << 10);
		h = h ^ (h >> 2);
		h = h + (h << 7);
		h = h ^ (h >> 12);
		return h;
	endfunction

	function automatic index_t index_mask(input log2_t log2);
		logic [CRC_W-1:0] m;
		m = ~(32'hFFFF_FFFF << log2);
		return m[INDEX_W-1:0];
	endfunction

endpackage

// ----- hdl/string_key_bucket_hash_unit.sv -----
// ---------------------------------------------------------------------------
// String key bucket hash unit
// Bytewise CRC-32 of a key, 64-bit mix and multiplicative reduction to a
// bucket index.
// ---------------------------------------------------------------------------
// Takes one key byte per cycle; every key byte, and the byte-less final item
// of an empty key, is one transfer. The running CRC-32 (reflected, zero
// start, no final inversion) is updated in the input cycle, so back-to-back
// bytes of one key and back-to-back keys run at one item per clock. Each
// final item enters a four-stage pipeline (CRC capture, two mix halves,
// 31-bit multiply) and its result is driven from the multiply stage register.
// Stages hold under backpressure and bubbles close up, so input keeps
// flowing while a result waits, until four results are waiting.
// table_size_log2 is applied at the output and should only be written
// while no key is in flight.
// ---------------------------------------------------------------------------
module string_key_bucket_hash_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [skbh_pkg::LOG2_W-1:0]   table_size_log2,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [skbh_pkg::BYTE_W-1:0]   key_byte,
	input  logic                          has_byte,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [skbh_pkg::INDEX_W-1:0]  bucket_index,
	output logic [skbh_pkg::CRC_W-1:0]    key_crc
);
	import skbh_pkg::*;

	log2_t  table_log2_q;
	crc_t   crc_acc_q;
	crc_t   crc_next;
	logic   in_xfer;

	logic   v_s1, v_s2, v_s3, v_s4;
	logic   free_s1, free_s2, free_s3, free_s4;
	crc_t   crc_s1, crc_s2, crc_s3, crc_s4;
	hash_t  hash_s2, hash_s3;
	index_t prod_s4;
	index_t prod_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_log2_q <= TABLE_LOG2_RST;
		end else if (cfg_valid) begin
			table_log2_q <= table_size_log2;
		end
	end

	assign free_s4 = !v_s4 || out_ready;
	assign free_s3 = !v_s3 || free_s4;
	assign free_s2 = !v_s2 || free_s3;
	assign free_s1 = !v_s1 || free_s2;
	assign in_ready = free_s1;
	assign in_xfer = in_valid && in_ready;

	assign crc_next = has_byte ? crc_byte(crc_acc_q, key_byte) : crc_acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc_q <= '0;
		end else if (in_xfer) begin
			crc_acc_q <= last ? '0 : crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1 <= in_valid && last;
			end
			if (free_s2) begin
				v_s2 <= v_s1;
			end
			if (free_s3) begin
				v_s3 <= v_s2;
			end
			if (free_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign prod_full = hash_s3[INDEX_W+2:3] * MIX_MULT_LO;

	always_ff @(posedge clk) begin
		if (free_s1) begin
			crc_s1 <= crc_next;
		end
		if (free_s2) begin
			crc_s2  <= crc_s1;
			hash_s2 <= mix_lo({32'd0, crc_s1});
		end
		if (free_s3) begin
			crc_s3  <= crc_s2;
			hash_s3 <= mix_hi(hash_s2);
		end
		if (free_s4) begin
			crc_s4  <= crc_s3;
			prod_s4 <= prod_full;
		end
	end

	assign out_valid    = v_s4;
	assign key_crc      = crc_s4;
	assign bucket_index = prod_s4 & index_mask(table_log2_q);

endmodule

// ----- hdl/skbh_checker.sv -----
// ---------------------------------------------------------------------------
// String key bucket hash port checker
// Port-level assertions on the hash unit, bound into the hash unit module.
// ---------------------------------------------------------------------------
`include "string_key_bucket_hash_unit_macros.svh"

module skbh_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [skbh_pkg::INDEX_W-1:0]  bucket_index,
	input  logic [skbh_pkg::CRC_W-1:0]    key_crc
);
	import skbh_pkg::*;

	// hold a stalled result
	`SKBH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bucket_index) && $stable(key_crc))

	// mix and multiply of a zero CRC give bucket zero
	`SKBH_ASSERT_IMP(a_zero_crc, out_valid && key_crc == '0, bucket_index == '0)

	// an empty output stage never blocks input
	`SKBH_ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready)

	// drop results during reset
	`SKBH_ASSERT_ALWAYS(a_reset_clear, !arst_n, !out_valid)

endmodule

bind string_key_bucket_hash_unit skbh_checker u_skbh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.bucket_index (bucket_index),
	.key_crc      (key_crc)
);

// ----- test/tb_string_key_bucket_hash_unit.sv -----
// ---------------------------------------------------------------------------
// String key bucket hash unit testbench
// Streams keys byte by byte through the hash unit under random gaps and
// output stalls, predicts CRC and bucket index per key, and compares every
// result transfer in order while the table size is stepped between phases.
// ---------------------------------------------------------------------------
module tb_string_key_bucket_hash_unit;
	import skbh_pkg::*;

	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 12;

	localparam logic [CRC_W-1:0]  REFL_POLY = 32'hEDB8_8320;
	localparam logic [HASH_W-1:0] GOLD_MULT = 64'd2654435761;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              has_byte;
		logic              last;
		logic [3:0]        gap;
	} key_item_t;

	typedef struct packed {
		index_t bucket;
		crc_t   crc;
	} bucket_entry_t;

	logic                clk             = 1'b0;
	logic                arst_n;
	logic                cfg_valid       = 1'b0;
	logic                cfg_ready;
	log2_t               table_size_log2 = TABLE_LOG2_RST;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   key_byte        = '0;
	logic                has_byte        = 1'b0;
	logic                last            = 1'b0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	index_t              bucket_index;
	crc_t                key_crc;

	key_item_t     item_q[$];
	bucket_entry_t bucket_q[$];

	crc_t  key_crc_acc = '0;
	log2_t bucket_log2 = TABLE_LOG2_RST;

	logic in_xfer  = 1'b0;
	logic out_xfer = 1'b0;
	bit   tx_burst = 1'b0;
	bit   rx_burst = 1'b0;
	bit   hold_req = 1'b0;
	bit   hold_done = 1'b0;
	int   tx_wait   = 0;
	int   rx_wait   = 0;
	int   hold_left = 0;
	int   cycles    = 0;
	int   errors    = 0;
	int   n_items   = 0;
	int   n_keys    = 0;
	int   n_results = 0;
	int   n_configs = 0;

	string_key_bucket_hash_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.table_size_log2 (table_size_log2),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_byte        (key_byte),
		.has_byte        (has_byte),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bucket_index    (bucket_index),
		.key_crc         (key_crc)
	);

	always #5 clk = ~clk;

	function automatic crc_t crc32_update(input crc_t acc, input logic [BYTE_W-1:0] b);
		crc_t c;
		c = acc ^ crc_t'(b);
		repeat (BYTE_W) c = (c >> 1) ^ (REFL_POLY & {CRC_W{c[0]}});
		return c;
	endfunction

	function automatic index_t bucket_of(input crc_t crc, input log2_t lg);
		logic [HASH_W-1:0] h;
		logic [HASH_W-1:0] mask;
		h = {32'd0, crc};
		h += h << 12;
		h ^= h >> 22;
		h += h << 4;
		h ^= h >> 9;
		h += h << 10;
		h ^= h >> 2;
		h += h << 7;
		h ^= h >> 12;
		h = (h >> 3) * GOLD_MULT;
		mask = (64'd1 << lg) - 64'd1;
		return index_t'(h & mask);
	endfunction

	function automatic int pick_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return 8'h00;
		end else if (roll == 1) begin
			return 8'hFF;
		end
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
	endtask

	task automatic push_item(input logic [BYTE_W-1:0] data, input logic hb, input logic lst);
		key_item_t it;
		it.data     = data;
		it.has_byte = hb;
		it.last     = lst;
		it.gap      = 4'(pick_gap(tx_burst));
		item_q.push_back(it);
	endtask

	// well-formed keys with random content, some stray byte-less items
	task automatic queue_keys(input int budget, input int max_len);
		int made;
		int len;
		int roll;
		made = 0;
		while (made < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				push_item(pick_byte(), 1'b0, 1'b1);
				made++;
			end else begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 24)
					: $urandom_range(1, max_len);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						push_item(pick_byte(), 1'b0, 1'b0);
					end
					push_item(pick_byte(), 1'b1, (k == len - 1) && (roll >= 12));
					made++;
				end
				if (roll < 12) begin
					push_item(pick_byte(), 1'b0, 1'b1);
					made++;
				end
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (item_q.size() != 0 || in_valid || bucket_q.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_table_log2(input log2_t v);
		@(negedge clk);
		cfg_valid       <= 1'b1;
		table_size_log2 <= v;
		do @(posedge clk); while (!cfg_ready);
		bucket_log2 = v;
		n_configs++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : monitor
		bucket_entry_t want;
		bucket_entry_t made;
		cycles++;
		in_xfer  <= arst_n && in_valid && in_ready;
		out_xfer <= arst_n && out_valid && out_ready;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (bucket_q.size() == 0) begin
				report_mismatch("result with nothing expected", 64'(key_crc), 64'd0);
			end else begin
				want = bucket_q.pop_front();
				if (bucket_index !== want.bucket) begin
					report_mismatch("bucket_index", 64'(bucket_index), 64'(want.bucket));
				end
				if (key_crc !== want.crc) begin
					report_mismatch("key_crc", 64'(key_crc), 64'(want.crc));
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			n_items++;
			if (has_byte) begin
				key_crc_acc = crc32_update(key_crc_acc, key_byte);
			end
			if (last) begin
				made.bucket = bucket_of(key_crc_acc, bucket_log2);
				made.crc    = key_crc_acc;
				bucket_q.push_back(made);
				key_crc_acc = '0;
				n_keys++;
			end
		end
	end

	always @(negedge clk) begin : driver
		key_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_xfer) begin
			// hold until transfer
		end else if (tx_wait > 0) begin
			tx_wait--;
			in_valid <= 1'b0;
		end else if (item_q.size() == 0) begin
			in_valid <= 1'b0;
		end else begin
			nxt = item_q.pop_front();
			key_byte <= nxt.data;
			has_byte <= nxt.has_byte;
			last     <= nxt.last;
			in_valid <= 1'b1;
			tx_wait  = nxt.gap;
		end
	end

	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
				hold_done = 1'b1;
			end
			if (out_xfer) begin
				rx_wait = pick_gap(rx_burst);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		log2_t settings[9];
		arst_n <= 1'b0;
		settings = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd5, 5'd24, 5'd30, 5'd12, 5'd8};
		settings[7] = log2_t'($urandom_range(0, 31));
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed keys at the reset table size
		push_item(8'h5A, 1'b0, 1'b1);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hFF, 1'b1, 1'b1);
		push_item(8'h80, 1'b1, 1'b0);
		push_item(8'h33, 1'b0, 1'b0);
		push_item(8'h01, 1'b1, 1'b1);
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'hC3, 1'b0, 1'b1);
		push_item(8'h55, 1'b1, 1'b0);
		push_item(8'hAA, 1'b1, 1'b1);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b0);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hFF, 1'b1, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0);
		push_item(8'hFF, 1'b1, 1'b1);
		push_item(8'hFF, 1'b0, 1'b1);
		wait_drained();

		for (int p = 0; p < 9; p++) begin
			write_table_log2(settings[p]);
			tx_burst = (p == 1) || (p == 3) || (p == 6);
			rx_burst = (p == 3) || (p == 5);
			if (p == 1) begin
				@(posedge clk);
				hold_req = 1'b1;
				queue_keys(115, 2);
			end else begin
				queue_keys(115, 8);
			end
			wait_drained();
		end

		$display("summary: %0d items, %0d keys, %0d results, %0d table size writes",
			n_items, n_keys, n_results, n_configs);
		$display("summary: empty keys, stray byte-less items, long output hold-off %0s",
			hold_done ? "covered" : "missed");
		if (errors == 0 && bucket_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
